// ===== src/jsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsf_pkg
// Types, constants and the round function of the JSF64 generator.
// ----------------------------------------------------------------------------
package jsf_pkg;

  localparam logic [63:0] SEED_A = 64'h0000_0000_f1ea_5eed;

  localparam int unsigned ROT_B = 7;
  localparam int unsigned ROT_C = 13;
  localparam int unsigned ROT_D = 37;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  localparam logic REQ_RESEED = 1'b0;
  localparam logic REQ_DRAW   = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] range_lo;
    logic signed [31:0] range_hi;
  } jsf_in_t;

  typedef struct packed {
    logic               was_reseed;
    logic        [63:0] raw_value;
    logic signed [31:0] scaled_value;
  } jsf_out_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } jsf_words_t;

  typedef struct packed {
    logic               was_reseed;
    logic        [63:0] raw_value;
    logic signed [31:0] range_lo;
    logic signed [31:0] range_hi;
  } jsf_issue_t;

  typedef enum logic [0:0] {
    CORE_RUN,
    CORE_WARM
  } core_state_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned k);
    return (x << k) | (x >> (64 - k));
  endfunction

  function automatic jsf_words_t jsf_round(input jsf_words_t s);
    logic [63:0] e;
    jsf_words_t  n;
    e   = s.a - rotl64(s.b, ROT_B);
    n.a = s.b ^ rotl64(s.c, ROT_C);
    n.b = s.c + rotl64(s.d, ROT_D);
    n.c = s.d + e;
    n.d = e + n.a;
    return n;
  endfunction

endpackage

// ===== src/jsf64_random_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsf64_random_generator
// JSF64 generator: reseed with warm-up, draws of raw and range-scaled values.
//
//   channel  ports                              dir  payload
//   in       in_valid / in_ready / in_data      in   jsf_in_t request item
//   out      out_valid / out_ready / out_data   out  jsf_out_t result item
//   cfg      cfg_valid / cfg_ready / cfg_seed   in   64-bit seed, always ready
//
// Draws run one round per cycle while the output is not stalled. A draw
// passes from the input accept through the queue, the round with first
// scaling stage, two more scaling stages and the output register. A reseed
// holds the core for the seed load, WARMUP_ROUNDS rounds and its acknowledge.
// Reset clears state words and seed. An output stall stops the scaling
// pipeline; the 4-entry request queue keeps taking items until full.
// ----------------------------------------------------------------------------
module jsf64_random_generator #(
  parameter int unsigned WARMUP_ROUNDS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  jsf_pkg::jsf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output jsf_pkg::jsf_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [63:0]       cfg_seed
);

  logic [63:0]         seed_r, seed_nxt;
  logic                q_valid, q_pop;
  jsf_pkg::jsf_in_t    q_item;
  logic                iss_valid, iss_ready;
  jsf_pkg::jsf_issue_t iss_data;

  assign cfg_ready = 1'b1;
  assign seed_nxt  = (cfg_valid & cfg_ready) ? cfg_seed : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  jsf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  jsf_core #(
    .WARMUP_ROUNDS (WARMUP_ROUNDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed      (seed_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .iss_valid (iss_valid),
    .iss_data  (iss_data),
    .iss_ready (iss_ready)
  );

  jsf_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss_valid (iss_valid),
    .iss_data  (iss_data),
    .iss_ready (iss_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/jsf_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsf_fifo
// Front end: takes request items and queues them for the generator core.
// ----------------------------------------------------------------------------
module jsf_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  jsf_pkg::jsf_in_t in_data,
  output logic             q_valid,
  output jsf_pkg::jsf_in_t q_item,
  input  logic             q_pop
);

  jsf_pkg::jsf_in_t                   mem_r [jsf_pkg::QDEPTH];
  logic [jsf_pkg::QPTR_W-1:0]         wptr_r, wptr_nxt;
  logic [jsf_pkg::QPTR_W-1:0]         rptr_r, rptr_nxt;
  logic [jsf_pkg::QCNT_W-1:0]         cnt_r, cnt_nxt;
  logic                               wr;

  assign in_ready = (cnt_r != jsf_pkg::QCNT_W'(jsf_pkg::QDEPTH));
  assign wr       = in_valid & in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wr ? wptr_r + jsf_pkg::QPTR_W'(1) : wptr_r;
    rptr_nxt = q_pop ? rptr_r + jsf_pkg::QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r + jsf_pkg::QCNT_W'(wr) - jsf_pkg::QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wptr_r] <= in_data;
    end
  end

endmodule

// ===== src/jsf_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsf_core
// Generator state and round sequencer: one round per draw, warm-up on reseed.
// ----------------------------------------------------------------------------
module jsf_core #(
  parameter int unsigned WARMUP_ROUNDS = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [63:0]         seed,
  input  logic                q_valid,
  input  jsf_pkg::jsf_in_t    q_item,
  output logic                q_pop,
  output logic                iss_valid,
  output jsf_pkg::jsf_issue_t iss_data,
  input  logic                iss_ready
);

  localparam int unsigned CNT_W = $clog2(WARMUP_ROUNDS + 2);

  jsf_pkg::core_state_t st_r, st_nxt;
  jsf_pkg::jsf_words_t  words_r, words_nxt;
  jsf_pkg::jsf_words_t  rnd;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  assign rnd = jsf_pkg::jsf_round(words_r);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      jsf_pkg::CORE_RUN: begin
        if (q_valid && q_item.req_type == jsf_pkg::REQ_RESEED) begin
          st_nxt = jsf_pkg::CORE_WARM;
        end
      end
      jsf_pkg::CORE_WARM: begin
        if (cnt_r == '0 && iss_ready) begin
          st_nxt = jsf_pkg::CORE_RUN;
        end
      end
      default: st_nxt = jsf_pkg::CORE_RUN;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    iss_valid = 1'b0;
    iss_data  = '0;
    words_nxt = words_r;
    cnt_nxt   = cnt_r;
    case (st_r)
      jsf_pkg::CORE_RUN: begin
        if (q_valid) begin
          if (q_item.req_type == jsf_pkg::REQ_RESEED) begin
            q_pop     = 1'b1;
            words_nxt = '{a: jsf_pkg::SEED_A, b: seed, c: seed, d: seed};
            cnt_nxt   = CNT_W'(WARMUP_ROUNDS);
          end else begin
            iss_valid          = 1'b1;
            iss_data.raw_value = rnd.d;
            iss_data.range_lo  = q_item.range_lo;
            iss_data.range_hi  = q_item.range_hi;
            if (iss_ready) begin
              q_pop     = 1'b1;
              words_nxt = rnd;
            end
          end
        end
      end
      jsf_pkg::CORE_WARM: begin
        if (cnt_r != '0) begin
          words_nxt = rnd;
          cnt_nxt   = cnt_r - CNT_W'(1);
        end else begin
          iss_valid           = 1'b1;
          iss_data.was_reseed = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= jsf_pkg::CORE_RUN;
      cnt_r   <= '0;
      words_r <= '0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      words_r <= words_nxt;
    end
  end

endmodule

// ===== src/jsf_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsf_scale
// Back end: maps the raw word into [lo,hi] as lo + floor((hi-lo)*raw/2^64),
// two 32x32 partial products over stages, then the output register.
// ----------------------------------------------------------------------------
module jsf_scale (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                iss_valid,
  input  jsf_pkg::jsf_issue_t iss_data,
  output logic                iss_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output jsf_pkg::jsf_out_t   out_data
);

  logic        adv;
  logic [32:0] diff, mag33;

  logic        s1_v_r, s2_v_r, s3_v_r, o_v_r;
  logic        s1_f_r, s2_f_r, s3_f_r;
  logic        s1_neg_r, s2_neg_r, s3_neg_r;
  logic [31:0] s1_lo_r, s2_lo_r, s3_lo_r;
  logic [63:0] s1_raw_r, s2_raw_r, s3_raw_r;
  logic [31:0] s1_mag_r, s2_mag_r;
  logic [63:0] s2_t1_r;
  logic [63:0] s3_t2_r, t2_nxt;
  logic        s3_rem_r;
  logic [31:0] q, res;
  logic        rem;
  jsf_pkg::jsf_out_t o_r, o_nxt;

  assign adv       = !o_v_r | out_ready;
  assign iss_ready = adv;
  assign out_valid = o_v_r;
  assign out_data  = o_r;

  always_comb begin
    diff  = {iss_data.range_hi[31], iss_data.range_hi}
          - {iss_data.range_lo[31], iss_data.range_lo};
    mag33 = diff[32] ? 33'd0 - diff : diff;
  end

  assign t2_nxt = 64'(s2_mag_r) * 64'(s2_raw_r[63:32]) + {32'd0, s2_t1_r[63:32]};

  always_comb begin
    q     = s3_t2_r[63:32];
    rem   = s3_rem_r | (s3_t2_r[31:0] != '0);
    res   = s3_neg_r ? s3_lo_r - q - 32'(rem) : s3_lo_r + q;
    o_nxt = '{was_reseed: s3_f_r, raw_value: s3_raw_r, scaled_value: res};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (adv) begin
      s1_v_r <= iss_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      o_v_r  <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_f_r   <= iss_data.was_reseed;
      s1_neg_r <= diff[32];
      s1_lo_r  <= iss_data.range_lo;
      s1_raw_r <= iss_data.raw_value;
      s1_mag_r <= mag33[31:0];

      s2_f_r   <= s1_f_r;
      s2_neg_r <= s1_neg_r;
      s2_lo_r  <= s1_lo_r;
      s2_raw_r <= s1_raw_r;
      s2_mag_r <= s1_mag_r;
      s2_t1_r  <= 64'(s1_mag_r) * 64'(s1_raw_r[31:0]);

      s3_f_r   <= s2_f_r;
      s3_neg_r <= s2_neg_r;
      s3_lo_r  <= s2_lo_r;
      s3_raw_r <= s2_raw_r;
      s3_t2_r  <= t2_nxt;
      s3_rem_r <= (s2_t1_r[31:0] != '0);

      o_r      <= o_nxt;
    end
  end

endmodule

// ===== dv/jsf64_random_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsf64_random_generator_tb
// Self-checking bench for the JSF64 generator. A short table of directed
// requests covers the zero state before any reseed, range extremes, reversed
// and equal ends, then four phases of random reseed/draw items run with
// different seeds and sender/receiver idling. Each result item is compared
// field by field to table values or an in-bench model of rounds and scaling.
// ----------------------------------------------------------------------------
module jsf64_random_generator_tb;

  localparam int unsigned WARMUP       = 20;
  localparam int unsigned PHASE_ITEMS  = 458;
  localparam int unsigned NUM_DIR      = 20;
  localparam logic [31:0] Q_MIN        = 32'h8000_0000;
  localparam logic [31:0] Q_MAX        = 32'h7fff_ffff;
  localparam logic [31:0] Q_ONE        = 32'h0001_0000;

  typedef struct packed {
    logic              known;
    jsf_pkg::jsf_in_t  req;
    jsf_pkg::jsf_out_t res;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{1'b1, '{jsf_pkg::REQ_DRAW, Q_MIN, Q_MAX}, '{1'b0, 64'd0, Q_MIN}},
    '{1'b1, '{jsf_pkg::REQ_DRAW, Q_MAX, Q_MIN}, '{1'b0, 64'd0, Q_MAX}},
    '{1'b1, '{jsf_pkg::REQ_DRAW, 32'd0, 32'd0}, '{1'b0, 64'd0, 32'd0}},
    '{1'b1, '{jsf_pkg::REQ_RESEED, 32'hffff_ffff, 32'hffff_ffff}, '{1'b1, 64'd0, 32'd0}},
    '{1'b0, '{jsf_pkg::REQ_DRAW, Q_MIN, Q_MAX}, '0},
    '{1'b0, '{jsf_pkg::REQ_DRAW, Q_MAX, Q_MIN}, '0},
    '{1'b0, '{jsf_pkg::REQ_DRAW, 32'd0, Q_ONE}, '0},
    '{1'b0, '{jsf_pkg::REQ_DRAW, Q_ONE, 32'd0}, '0},
    '{1'b0, '{jsf_pkg::REQ_DRAW, 32'h1234_5678, 32'h1234_5678}, '0},
    '{1'b0, '{jsf_pkg::REQ_DRAW, 32'hffff_ffff, 32'hffff_ffff}, '0},
    '{1'b0, '{jsf_pkg::REQ_DRAW, Q_MIN, Q_MIN}, '0},
    '{1'b0, '{jsf_pkg::REQ_DRAW, Q_MAX, Q_MAX}, '0},
    '{1'b0, '{jsf_pkg::REQ_DRAW, 32'hffff_0000, Q_ONE}, '0},
    '{1'b0, '{jsf_pkg::REQ_DRAW, 32'd0, Q_MAX}, '0},
    '{1'b0, '{jsf_pkg::REQ_DRAW, Q_MIN, 32'd0}, '0},
    '{1'b1, '{jsf_pkg::REQ_RESEED, 32'd0, 32'd0}, '{1'b1, 64'd0, 32'd0}},
    '{1'b0, '{jsf_pkg::REQ_DRAW, Q_MIN, Q_MAX}, '0},
    '{1'b0, '{jsf_pkg::REQ_DRAW, Q_MAX, Q_MIN}, '0},
    '{1'b0, '{jsf_pkg::REQ_DRAW, 32'hffff_ffff, 32'd0}, '0},
    '{1'b0, '{jsf_pkg::REQ_DRAW, 32'd0, 32'hffff_ffff}, '0}
  };

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  jsf_pkg::jsf_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  jsf_pkg::jsf_out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [63:0]       cfg_seed  = '0;

  // generator model state
  logic [63:0] seed_reg = '0;
  logic [63:0] gen_a = '0, gen_b = '0, gen_c = '0, gen_d = '0;

  jsf_pkg::jsf_out_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;

  jsf64_random_generator #(
    .WARMUP_ROUNDS(WARMUP)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_seed (cfg_seed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic advance_generator(output logic [63:0] new_d);
    logic [63:0] e;
    logic [63:0] na;
    e     = gen_a - {gen_b[56:0], gen_b[63:57]};
    na    = gen_b ^ {gen_c[50:0], gen_c[63:51]};
    gen_b = gen_c + {gen_d[26:0], gen_d[63:27]};
    gen_c = gen_d + e;
    gen_d = e + na;
    gen_a = na;
    new_d = gen_d;
  endtask

  // lo + floor((hi - lo) * raw / 2^64), exact
  function automatic logic [31:0] map_to_range(logic [31:0] lo, logic [31:0] hi,
                                               logic [63:0] raw);
    logic signed [32:0] span;
    logic signed [97:0] prod;
    logic signed [97:0] quot;
    span = {hi[31], hi} - {lo[31], lo};
    prod = $signed({{65{span[32]}}, span}) * $signed({34'd0, raw});
    quot = prod >>> 64;
    return lo + quot[31:0];
  endfunction

  task automatic predict_result(input jsf_pkg::jsf_in_t req, output jsf_pkg::jsf_out_t res);
    logic [63:0] raw;
    res = '0;
    if (req.req_type == jsf_pkg::REQ_RESEED) begin
      gen_a = jsf_pkg::SEED_A;
      gen_b = seed_reg;
      gen_c = seed_reg;
      gen_d = seed_reg;
      for (int i = 0; i < WARMUP; i++) advance_generator(raw);
      res.was_reseed = 1'b1;
    end else begin
      advance_generator(raw);
      res.raw_value    = raw;
      res.scaled_value = map_to_range(req.range_lo, req.range_hi, raw);
    end
  endtask

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_request(input jsf_pkg::jsf_in_t req, input logic known,
                              input jsf_pkg::jsf_out_t fixed);
    jsf_pkg::jsf_out_t res;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predict_result(req, res);
    pending_results.push_back(known ? fixed : res);
    @(negedge clk);
  endtask

  task automatic write_seed(input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_seed  <= value;
    do @(posedge clk); while (!cfg_ready);
    seed_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_end();
    case ($urandom_range(3))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return 32'd0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic jsf_pkg::jsf_in_t random_request();
    jsf_pkg::jsf_in_t r;
    r.req_type = ($urandom_range(99) < 5) ? jsf_pkg::REQ_RESEED : jsf_pkg::REQ_DRAW;
    r.range_lo = $urandom;
    r.range_hi = $urandom;
    case ($urandom_range(5))
      0: r.range_hi = r.range_lo;
      1: begin
        r.range_lo = pick_end();
        r.range_hi = pick_end();
      end
      2: r.range_hi = r.range_lo + $urandom_range(0, 32'h0002_0000);
      3: r.range_hi = r.range_lo - $urandom_range(0, 32'h0002_0000);
      default: ;
    endcase
    return r;
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    jsf_pkg::jsf_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.was_reseed !== want.was_reseed ||
            out_data.raw_value !== want.raw_value ||
            out_data.scaled_value !== want.scaled_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: reseed %b/%b raw %h/%h scaled %h/%h (exp/act)",
                     want.was_reseed, out_data.was_reseed,
                     want.raw_value, out_data.raw_value,
                     want.scaled_value, out_data.scaled_value);
        end
      end
    end
  end

  initial begin
    logic [63:0] phase_seed;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // seed is still at its reset value here
    for (int i = 0; i < NUM_DIR; i++)
      send_request(DIR_ROWS[i].req, DIR_ROWS[i].known, DIR_ROWS[i].res);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          in_idle_pct = 0;   out_stall_pct = 0;  phase_seed = '0;
        end
        1: begin
          in_idle_pct = 59;  out_stall_pct = 0;  phase_seed = '1;
        end
        2: begin
          in_idle_pct = 0;   out_stall_pct = 59; phase_seed = {$urandom, $urandom};
        end
        default: begin
          in_idle_pct = 28;  out_stall_pct = 28; phase_seed = {$urandom, $urandom};
        end
      endcase
      write_seed(phase_seed);
      send_request('{jsf_pkg::REQ_RESEED, 32'd0, 32'd0}, 1'b0, '0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request(random_request(), 1'b0, '0);
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/jsf_pkg.sv
src/jsf_fifo.sv
src/jsf_core.sv
src/jsf_scale.sv
src/jsf64_random_generator.sv
dv/jsf64_random_generator_tb.sv
